// ===== src/max_distance_seat_allocator_assert.svh =====
// Assertion macros for the seat allocator.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef MAX_DISTANCE_SEAT_ALLOCATOR_ASSERT_SVH
`define MAX_DISTANCE_SEAT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that cond_b holds in the same cycle as cond_a.
`define MDSA_ASSERT_NOW(lbl, cond_a, cond_b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_b)) else $error("seat allocator check failed");
// Checks that cond_b holds in the cycle after cond_a.
`define MDSA_ASSERT_NEXT(lbl, cond_a, cond_b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |=> (cond_b)) else $error("seat allocator check failed");
`else
`define MDSA_ASSERT_NOW(lbl, cond_a, cond_b)
`define MDSA_ASSERT_NEXT(lbl, cond_a, cond_b)
`endif
`endif

// ===== src/mdsa_pkg.sv =====
// Shared types and constants for the seat allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package mdsa_pkg;

    // Row geometry.
    localparam int MAX_SEATS = 256;
    localparam int SEAT_W    = $clog2(MAX_SEATS);
    localparam int CNT_W     = SEAT_W + 1;

    // Request kinds.
    localparam logic FN_TAKE    = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input word and clear the scan state
        logic rd;       // issue one occupancy read
        logic rd_seat;  // read at the release seat instead of the scan index
        logic fin;      // form the result from the scan state
        logic commit;   // update the map and load the output word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func;     // kind of the captured request
        logic idx_last; // scan index points at the last seat in use
    } t_sts;

endpackage

// ===== src/mdsa_ctrl.sv =====
// Controller state machine of the seat allocator.
// Depends on mdsa_pkg for the command and status structs.
module mdsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  mdsa_pkg::t_sts i_sts,
    output mdsa_pkg::t_cmd o_cmd
);
    import mdsa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RELRD = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RELRD;
                end
            end
            S_RELRD: begin
                // The first cycle after capture picks the request path.
                if (i_sts.func == FN_RELEASE) begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.rd_seat = 1'b1;
                    n_state       = S_WAIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output word stays valid until the receiver stops stalling.
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== src/mdsa_dp.sv =====
// Datapath of the seat allocator: occupancy map, gap scan and output word.
// Depends on mdsa_pkg for widths, codes and the command and status structs.
module mdsa_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mdsa_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_func,
    input  logic [mdsa_pkg::SEAT_W-1:0] i_leave_seat,
    input  mdsa_pkg::t_cmd             i_cmd,
    output mdsa_pkg::t_sts             o_sts,
    output logic [mdsa_pkg::SEAT_W-1:0] o_given_seat,
    output logic [1:0]                 o_status
);
    import mdsa_pkg::*;

    logic [CNT_W-1:0]     r_num_seats;
    logic [MAX_SEATS-1:0] r_occ;
    logic                 r_func;
    logic [SEAT_W-1:0]    r_seat;
    logic [SEAT_W-1:0]    r_idx;
    logic                 r_rd_vld;
    logic                 r_rd_bit;
    logic [SEAT_W-1:0]    r_rd_idx;
    logic                 r_any;
    logic                 r_have;
    logic [SEAT_W-1:0]    r_last;
    logic [SEAT_W-1:0]    r_best_d;
    logic [SEAT_W-1:0]    r_best_p;
    logic [SEAT_W-1:0]    r_res_seat;
    logic [1:0]           r_res_status;
    logic [SEAT_W-1:0]    r_out_seat;
    logic [1:0]           r_out_status;

    logic [CNT_W-1:0]  n_active;
    logic [SEAT_W-1:0] n_m1;
    logic [SEAT_W-1:0] rd_addr;
    logic [SEAT_W-1:0] gap;
    logic [SEAT_W-1:0] half;
    logic [SEAT_W-1:0] end_d;
    logic              end_win;
    logic              rel_ok;
    logic [SEAT_W-1:0] wr_addr;

    // Seats in use: a zero count acts as one, a large count as the full row.
    always_comb begin
        if (r_num_seats == '0) begin
            n_active = CNT_W'(1);
        end else if (r_num_seats > CNT_W'(MAX_SEATS)) begin
            n_active = CNT_W'(MAX_SEATS);
        end else begin
            n_active = r_num_seats;
        end
    end
    assign n_m1 = SEAT_W'(n_active - CNT_W'(1));

    assign o_sts.func     = r_func;
    assign o_sts.idx_last = (r_idx == n_m1);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_seats <= CNT_W'(MAX_SEATS);
        end else if (i_cfg_we) begin
            r_num_seats <= i_cfg_data;
        end
    end

    // Captured request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_seat <= i_leave_seat;
        end
    end

    // Scan index and registered occupancy read, one seat per cycle.
    assign rd_addr = i_cmd.rd_seat ? r_seat : r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.rd && !i_cmd.rd_seat) begin
                r_idx <= r_idx + SEAT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_bit <= r_occ[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

    // Gap tracking: each occupied seat closes the gap behind it.
    assign gap  = r_rd_idx - r_last;
    assign half = gap >> 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_any    <= 1'b0;
            r_have   <= 1'b0;
            r_last   <= '0;
            r_best_d <= '0;
            r_best_p <= '0;
        end else if (r_rd_vld && r_func == FN_TAKE && r_rd_bit) begin
            if (!r_any) begin
                // Gap at the left end counts in full.
                if (r_rd_idx != '0) begin
                    r_best_d <= r_rd_idx;
                    r_best_p <= '0;
                    r_have   <= 1'b1;
                end
            end else if (gap >= SEAT_W'(2)) begin
                if (!r_have || half > r_best_d) begin
                    r_best_d <= half;
                    r_best_p <= r_last + half;
                    r_have   <= 1'b1;
                end
            end
            r_any  <= 1'b1;
            r_last <= r_rd_idx;
        end
    end

    // Final step: gap at the right end, or the release check.
    assign end_d   = n_m1 - r_last;
    assign end_win = (r_last < n_m1) && (!r_have || end_d > r_best_d);
    assign rel_ok  = ({1'b0, r_seat} < n_active) && r_rd_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            if (r_func == FN_RELEASE) begin
                r_res_seat   <= '0;
                r_res_status <= rel_ok ? ST_OK : ST_FREE;
            end else if (!r_any) begin
                r_res_seat   <= '0;
                r_res_status <= ST_OK;
            end else if (end_win) begin
                r_res_seat   <= n_m1;
                r_res_status <= ST_OK;
            end else if (r_have) begin
                r_res_seat   <= r_best_p;
                r_res_status <= ST_OK;
            end else begin
                r_res_seat   <= '0;
                r_res_status <= ST_FULL;
            end
        end
    end

    // Map update and output word.
    assign wr_addr = (r_func == FN_RELEASE) ? r_seat : r_res_seat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.commit && r_res_status == ST_OK) begin
            r_occ[wr_addr] <= (r_func == FN_TAKE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_seat   <= r_res_seat;
            r_out_status <= r_res_status;
        end
    end

    assign o_given_seat = r_out_seat;
    assign o_status     = r_out_status;

endmodule

// ===== src/max_distance_seat_allocator.sv =====
// Seat allocator top level: controller and datapath, plus a few assertions.
// Depends on mdsa_pkg, mdsa_ctrl, mdsa_dp and max_distance_seat_allocator_assert.svh.
//
// Keeps an occupancy map of a row of num_seats seats, all free after reset. A take
// request returns the free seat farthest from its nearest occupied neighbor (end gaps
// count in full, inner gaps half their width, ties to the lowest index); a release
// request frees the named seat. One request is in flight at a time. A take scans the
// map one seat per cycle through a single read port; a release reads only the named
// seat. A finished word waits in an output register, so a new request is taken as
// soon as the previous one is done.
`include "max_distance_seat_allocator_assert.svh"
module max_distance_seat_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mdsa_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [mdsa_pkg::SEAT_W-1:0] i_leave_seat,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mdsa_pkg::SEAT_W-1:0] o_given_seat,
    output logic [1:0]                  o_status
);
    import mdsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The register can be written at any time.
    assign o_cfg_ready = 1'b1;

    mdsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mdsa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_leave_seat (i_leave_seat),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_given_seat (o_given_seat),
        .o_status     (o_status)
    );

    // An accepted word keeps the input side busy in the next cycle.
    `MDSA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // A failed request never names a seat.
    `MDSA_ASSERT_NOW(a_fail_no_seat, o_out_valid && o_status != ST_OK, o_given_seat == '0)
    // Only the three defined status codes are produced.
    `MDSA_ASSERT_NOW(a_status_code, o_out_valid, o_status <= ST_FREE)

endmodule
